/* rtl/core/miller_rabin_prime_test_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Miller-Rabin prime test block
// The macros expand to concurrent assertions, or to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define MRPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define MRPT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MRPT_ASSERT(lbl, clk, rstn, prop, msg)
`define MRPT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/core/mrpt_pkg.sv */
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared widths, codes and controller/datapath types of the prime test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrpt_pkg;

  localparam int unsigned CandW   = 62;
  localparam int unsigned WordW   = 31;
  localparam int unsigned ROUNDS  = 2;
  localparam int unsigned RoundW  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned DivCntW = $clog2(WordW + 1);

  typedef logic [CandW-1:0] cand_t;
  typedef logic [WordW-1:0] word_t;

  // verdict codes
  typedef enum logic [1:0] {
    ReasonPass     = 2'd0,
    ReasonBelowTwo = 2'd1,
    ReasonEven     = 2'd2,
    ReasonWitness  = 2'd3
  } reason_e;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    OpNone      = 4'd0,
    OpLoad      = 4'd1,
    OpStrip     = 4'd2,
    OpDivInit   = 4'd3,
    OpDivStep   = 4'd4,
    OpPowInit   = 4'd5,
    OpMulRes    = 4'd6,
    OpWbRes     = 4'd7,
    OpMulSq     = 4'd8,
    OpWbSq      = 4'd9,
    OpMulX      = 4'd10,
    OpWbX       = 4'd11,
    OpNextRound = 4'd12
  } dp_op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic below_two;
    logic even_not_two;
    logic s_odd;
    logic div_done;
    logic e_zero;
    logic e_lsb;
    logic sq_go;
    logic witness_fail;
    logic mul_done;
    logic last_round;
  } dp_status_t;

endpackage

/* rtl/core/mrpt_mulmod.sv */
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Shift-and-add modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_assert.svh"

module mrpt_mulmod import mrpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  cand_t a_i,
  input  cand_t b_i,
  input  cand_t m_i,
  output logic  busy_o,
  output logic  done_o,
  output cand_t res_o
);

  logic        busy_q;
  cand_t       acc_q, add_q, b_q;
  logic [CandW:0] acc_sum, acc_red, add_dbl, add_red, m_ext;

  // reduce acc + add and 2 * add, both below 2m
  always_comb begin
    m_ext   = {1'b0, m_i};
    acc_sum = {1'b0, acc_q} + {1'b0, add_q};
    acc_red = (acc_sum >= m_ext) ? (acc_sum - m_ext) : acc_sum;
    add_dbl = {add_q, 1'b0};
    add_red = (add_dbl >= m_ext) ? (add_dbl - m_ext) : add_dbl;
  end

  assign done_o = busy_q && (b_q == '0);
  assign busy_o = busy_q;
  assign res_o  = acc_q;

  // busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      add_q <= a_i;
      b_q   <= b_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_red[CandW-1:0];
      end
      add_q <= add_red[CandW-1:0];
      b_q   <= {1'b0, b_q[CandW-1:1]};
    end
  end

  `MRPT_ASSERT(a_acc_reduced, clk_i, rst_ni, busy_q |-> (acc_q < m_i), "accumulator not reduced")
  `MRPT_ASSERT(a_add_reduced, clk_i, rst_ni, busy_q |-> (add_q < m_i), "addend not reduced")
  `MRPT_ASSERT_NEVER(a_no_restart, clk_i, rst_ni, start_i && busy_q, "multiply started while busy")

endmodule

/* rtl/core/mrpt_datapath.sv */
// ----------------------------------------------------------------------------
// mrpt_datapath
// Operand registers, witness reduction, exponent and squaring registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_assert.svh"

module mrpt_datapath import mrpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_op_e     op_i,
  input  cand_t      candidate_i,
  input  word_t      random_first_i,
  input  word_t      random_second_i,
  output dp_status_t status_o
);

  cand_t               p_q, pm1_q, s_q, rem_q, e_q, t_q, x_q, sq_q;
  word_t               w0_q, w1_q, word_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [RoundW-1:0]   round_q;

  logic [CandW:0]      div_sh, div_red, pm1_ext;
  logic                mul_start, mul_busy, mul_done;
  cand_t               mul_a, mul_b, mul_res;

  // one restoring remainder step on the witness word
  always_comb begin
    pm1_ext = {1'b0, pm1_q};
    div_sh  = {rem_q, word_q[WordW-1]};
    div_red = (div_sh >= pm1_ext) ? (div_sh - pm1_ext) : div_sh;
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = x_q;
    mul_b     = sq_q;
    case (op_i)
      OpMulRes: begin
        mul_start = 1'b1;
      end
      OpMulSq: begin
        mul_start = 1'b1;
        mul_a     = sq_q;
      end
      OpMulX: begin
        mul_start = 1'b1;
        mul_b     = x_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (p_q),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
    end else if (op_i == OpLoad) begin
      round_q <= '0;
    end else if (op_i == OpNextRound) begin
      round_q <= round_q + RoundW'(1);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OpLoad: begin
        p_q   <= candidate_i;
        pm1_q <= candidate_i - CandW'(1);
        s_q   <= candidate_i - CandW'(1);
        w0_q  <= random_first_i;
        w1_q  <= random_second_i;
      end
      OpStrip: begin
        s_q <= {1'b0, s_q[CandW-1:1]};
      end
      OpDivInit: begin
        word_q    <= w0_q;
        rem_q     <= '0;
        div_cnt_q <= DivCntW'(WordW);
      end
      OpNextRound: begin
        word_q    <= w1_q;
        rem_q     <= '0;
        div_cnt_q <= DivCntW'(WordW);
      end
      OpDivStep: begin
        rem_q     <= div_red[CandW-1:0];
        word_q    <= {word_q[WordW-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end
      OpPowInit: begin
        x_q  <= CandW'(1);
        sq_q <= rem_q + CandW'(1);
        e_q  <= s_q;
        t_q  <= s_q;
      end
      OpWbRes: begin
        x_q <= mul_res;
      end
      OpWbSq: begin
        sq_q <= mul_res;
        e_q  <= {1'b0, e_q[CandW-1:1]};
      end
      OpWbX: begin
        x_q <= mul_res;
        t_q <= {t_q[CandW-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    status_o.below_two    = (p_q[CandW-1:1] == '0);
    status_o.even_not_two = !p_q[0] && (p_q != CandW'(2));
    status_o.s_odd        = s_q[0];
    status_o.div_done     = (div_cnt_q == '0);
    status_o.e_zero       = (e_q == '0);
    status_o.e_lsb        = e_q[0];
    status_o.sq_go        = (t_q != pm1_q) && (x_q != CandW'(1)) && (x_q != pm1_q);
    status_o.witness_fail = (x_q != pm1_q) && !t_q[0];
    status_o.mul_done     = mul_done;
    status_o.last_round   = (round_q == RoundW'(ROUNDS - 1));
  end

  `MRPT_ASSERT(a_witness_range, clk_i, rst_ni, (op_i == OpPowInit) |-> (rem_q < pm1_q), "witness out of range")
  `MRPT_ASSERT(a_square_bound, clk_i, rst_ni, (op_i == OpMulX) |-> (t_q < pm1_q), "squaring past p-1")
  `MRPT_ASSERT_NEVER(a_wb_idle, clk_i, rst_ni, ((op_i == OpWbRes) || (op_i == OpWbSq) || (op_i == OpWbX)) && !mul_busy, "write-back with no product")

endmodule

/* rtl/core/mrpt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrpt_ctrl
// Sequencer of the prime test and the output register of the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrpt_ctrl import mrpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       probably_prime_o,
  output logic [1:0] verdict_reason_o,
  output dp_op_e     op_o,
  input  dp_status_t status_i
);

  typedef enum logic [11:0] {
    StIdle     = 12'b0000_0000_0001,
    StClassify = 12'b0000_0000_0010,
    StStrip    = 12'b0000_0000_0100,
    StDiv      = 12'b0000_0000_1000,
    StPowBit   = 12'b0000_0001_0000,
    StPowMulR  = 12'b0000_0010_0000,
    StPowSqr   = 12'b0000_0100_0000,
    StPowMulS  = 12'b0000_1000_0000,
    StSqChk    = 12'b0001_0000_0000,
    StSqMul    = 12'b0010_0000_0000,
    StDecide   = 12'b0100_0000_0000,
    StFinish   = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  reason_e    reason_q, reason_d;
  logic       out_valid_q, out_valid_d;
  logic       out_prime_q;
  logic [1:0] out_reason_q;
  logic       out_free, out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == StFinish) && out_free;

  // next state and datapath command
  always_comb begin
    state_d  = state_q;
    reason_d = reason_q;
    op_o     = OpNone;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_o    = OpLoad;
          state_d = StClassify;
        end
      end
      StClassify: begin
        if (status_i.below_two) begin
          reason_d = ReasonBelowTwo;
          state_d  = StFinish;
        end else if (status_i.even_not_two) begin
          reason_d = ReasonEven;
          state_d  = StFinish;
        end else begin
          state_d = StStrip;
        end
      end
      StStrip: begin
        if (status_i.s_odd) begin
          op_o    = OpDivInit;
          state_d = StDiv;
        end else begin
          op_o = OpStrip;
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          op_o    = OpPowInit;
          state_d = StPowBit;
        end else begin
          op_o = OpDivStep;
        end
      end
      StPowBit: begin
        if (status_i.e_zero) begin
          state_d = StSqChk;
        end else if (status_i.e_lsb) begin
          op_o    = OpMulRes;
          state_d = StPowMulR;
        end else begin
          op_o    = OpMulSq;
          state_d = StPowMulS;
        end
      end
      StPowMulR: begin
        if (status_i.mul_done) begin
          op_o    = OpWbRes;
          state_d = StPowSqr;
        end
      end
      StPowSqr: begin
        op_o    = OpMulSq;
        state_d = StPowMulS;
      end
      StPowMulS: begin
        if (status_i.mul_done) begin
          op_o    = OpWbSq;
          state_d = StPowBit;
        end
      end
      StSqChk: begin
        if (status_i.sq_go) begin
          op_o    = OpMulX;
          state_d = StSqMul;
        end else begin
          state_d = StDecide;
        end
      end
      StSqMul: begin
        if (status_i.mul_done) begin
          op_o    = OpWbX;
          state_d = StSqChk;
        end
      end
      StDecide: begin
        if (status_i.witness_fail) begin
          reason_d = ReasonWitness;
          state_d  = StFinish;
        end else if (status_i.last_round) begin
          reason_d = ReasonPass;
          state_d  = StFinish;
        end else begin
          op_o    = OpNextRound;
          state_d = StDiv;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // verdict payload
  always_ff @(posedge clk_i) begin
    reason_q <= reason_d;
    if (out_load) begin
      out_prime_q  <= (reason_q == ReasonPass);
      out_reason_q <= reason_q;
    end
  end

  assign in_stall_o       = (state_q != StIdle);
  assign out_valid_o      = out_valid_q;
  assign probably_prime_o = out_prime_q;
  assign verdict_reason_o = out_reason_q;

endmodule

/* rtl/core/miller_rabin_prime_test.sv */
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Miller-Rabin probable-prime test of a 62-bit candidate with a verdict code.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | candidate, random_first, random_second
//  out     | output    | out_valid_o/out_stall_i | probably_prime, verdict_reason
//
//  A candidate below two or even (other than two) is classified in StClassify
//  and its verdict loaded from StFinish. Otherwise an item takes strip, then per
//  round a witness reduction and the modular exponentiation and
//  squarings, each product being one pass of the shift-add multiplier (one
//  multiplier bit per cycle). One item is worked on at a time; a new item
//  is taken while the last verdict still waits in the output register.
//  Reset clears the control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module miller_rabin_prime_test import mrpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cand_t      candidate_i,
  input  word_t      random_first_i,
  input  word_t      random_second_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       probably_prime_o,
  output logic [1:0] verdict_reason_o
);

  dp_op_e     dp_op;
  dp_status_t dp_status;

  // sequencer
  mrpt_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .probably_prime_o (probably_prime_o),
    .verdict_reason_o (verdict_reason_o),
    .op_o             (dp_op),
    .status_i         (dp_status)
  );

  // arithmetic
  mrpt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (dp_op),
    .candidate_i     (candidate_i),
    .random_first_i  (random_first_i),
    .random_second_i (random_second_i),
    .status_o        (dp_status)
  );

endmodule
